>>> sv/geodetic_to_ecef_core_macros.svh
// Assertion macros for the geodetic to ECEF core.
`ifndef GEODETIC_TO_ECEF_CORE_MACROS_SVH
`define GEODETIC_TO_ECEF_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define GEO_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define GEO_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define GEO_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define GEO_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif
`endif

>>> sv/geo_pkg.sv
// Constants, stage types and helper functions of the geodetic to ECEF core.
package geo_pkg;

   localparam int CORDIC_STEPS = 32;
   localparam int SQRT_STEPS   = 62;
   localparam int DIV_STEPS    = 107;
   localparam int SIDE_LEN     = 8 + 1 + SQRT_STEPS + DIV_STEPS;
   localparam int IDX_D        = CORDIC_STEPS + 10;
   localparam int IDX_SQ_LAST  = IDX_D + SQRT_STEPS;
   localparam int LAT          = IDX_D + SQRT_STEPS + DIV_STEPS + 12;

   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_ECC    = 1'b1;
   localparam logic [46:0] RADIUS_RESET = 47'd16777216;
   localparam logic [31:0] ECC_RESET    = 32'd28752012;

   localparam logic signed [63:0] PI_Q60         = 64'sh3243F6A8885A308D;
   localparam logic signed [63:0] HALF_PI_Q60    = 64'sh1921FB54442D1846;
   localparam logic signed [63:0] QUARTER_PI_Q60 = 64'sh0C90FDAA22168C23;
   localparam logic signed [63:0] K_Q60          = 64'sd700114967507363238;
   localparam logic signed [63:0] ONE_Q60        = 64'sd1 <<< 60;
   localparam logic signed [63:0] N_CAP          = 64'sd1 <<< 61;
   localparam logic signed [63:0] OUT_MAX        = 64'sd140737488355327;
   localparam logic signed [63:0] OUT_MIN        = -64'sd140737488355328;

   typedef struct packed {
      logic signed [63:0] x;
      logic signed [63:0] y;
      logic signed [63:0] z;
   } cord_type;

   typedef struct packed {
      cord_type           lat;
      cord_type           lon;
      logic               lat_flip;
      logic               lon_flip;
      logic signed [47:0] alt;
   } cstage_type;

   typedef struct packed {
      logic signed [63:0] sl;
      logic signed [63:0] cl;
      logic signed [63:0] so;
      logic signed [63:0] co;
      logic signed [47:0] alt;
   } trig_type;

   typedef struct packed {
      logic [63:0] rem;
      logic [63:0] root;
      logic [63:0] rad;
   } sqrt_type;

   typedef struct packed {
      logic [59:0] rem;
      logic [60:0] quo;
      logic [60:0] den;
      logic        ov;
   } div_type;

   typedef struct packed {
      logic signed [63:0] n;
      logic signed [63:0] h;
      logic signed [63:0] sl;
      logic signed [63:0] cl;
      logic signed [63:0] so;
      logic signed [63:0] co;
      logic signed [47:0] alt;
      logic               ov;
   } nh_type;

   typedef struct packed {
      logic signed [63:0] sl;
      logic signed [63:0] so;
      logic signed [63:0] co;
      logic signed [47:0] alt;
      logic               ov;
   } post_type;

   typedef struct packed {
      logic signed [63:0] hz;
      logic signed [63:0] hc;
      logic signed [63:0] sl;
      logic signed [63:0] so;
      logic signed [63:0] co;
      logic               ov;
   } hz_type;

   function automatic logic [63:0] const_div(logic [63:0] num, logic [63:0] den);
      logic [63:0] rem;
      logic [63:0] quo;
      rem = '0;
      quo = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[62:0], num[b]};
         quo = {quo[62:0], 1'b0};
         if (rem >= den) begin
            rem = rem - den;
            quo[0] = 1'b1;
         end
      end
      return quo;
   endfunction

   function automatic logic signed [63:0] atan_q60(int i);
      logic [63:0] acc;
      logic [63:0] t;
      int          e;
      acc = '0;
      if (i == 0) return QUARTER_PI_Q60;
      for (int k = 0; k < 32; k++) begin
         e = i * (2 * k + 1);
         if (e <= 62) begin
            t = const_div(64'd1 << (62 - e), 64'(2 * k + 1));
            if ((k & 1) == 1) acc = acc - t;
            else acc = acc + t;
         end
      end
      return signed'((acc + 64'd2) >> 2);
   endfunction

   function automatic cord_type cordic_step(cord_type c, int sh, logic signed [63:0] ang);
      cord_type r;
      r = c;
      if (!c.z[63]) begin
         r.x = c.x - (c.y >>> sh);
         r.y = c.y + (c.x >>> sh);
         r.z = c.z - ang;
      end else begin
         r.x = c.x + (c.y >>> sh);
         r.y = c.y - (c.x >>> sh);
         r.z = c.z + ang;
      end
      return r;
   endfunction

   function automatic sqrt_type sqrt_step(sqrt_type s, logic [1:0] pair);
      sqrt_type    r;
      logic [63:0] rem_n;
      logic [63:0] trial;
      r = s;
      rem_n = {s.rem[61:0], pair};
      trial = {s.root[61:0], 2'b01};
      if (rem_n >= trial) begin
         r.rem = rem_n - trial;
         r.root = {s.root[62:0], 1'b1};
      end else begin
         r.rem = rem_n;
         r.root = {s.root[62:0], 1'b0};
      end
      return r;
   endfunction

   function automatic div_type div_step(div_type s, logic bitv);
      div_type     r;
      logic [60:0] rem_n;
      logic [61:0] q_n;
      r = s;
      rem_n = {s.rem, bitv};
      q_n = {s.quo, 1'b0};
      if (!s.ov) begin
         if (rem_n >= s.den) begin
            rem_n = rem_n - s.den;
            q_n[0] = 1'b1;
         end
         r.rem = rem_n[59:0];
         if (q_n >= N_CAP[61:0]) r.ov = 1'b1;
         else r.quo = q_n[60:0];
      end
      return r;
   endfunction

   function automatic logic [48:0] sat48(logic signed [63:0] v);
      if (v > OUT_MAX) return {1'b1, OUT_MAX[47:0]};
      if (v < OUT_MIN) return {1'b1, OUT_MIN[47:0]};
      return {1'b0, v[47:0]};
   endfunction

endpackage

>>> sv/geo_mul.sv
// Pipelined signed 64x64 multiply with rounding, scaling and magnitude cap.
module geo_mul (
   input  logic               clock,
   input  logic               adv,
   input  logic               frac32,
   input  logic signed [63:0] a,
   input  logic signed [63:0] b,
   output logic signed [63:0] prod
);
   import geo_pkg::*;

   logic [63:0]         ua_ff, ub_ff;
   logic                neg1_ff, neg2_ff, neg3_ff;
   logic [63:0]         p00_ff, p01_ff, p10_ff, p11_ff;
   logic [127:0]        sum_ff;
   logic [127:0]        half, rnd, shf;
   logic [62:0]         mag;
   logic signed [63:0]  prod_in, prod_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         ua_ff   <= a[63] ? 64'(-a) : a;
         ub_ff   <= b[63] ? 64'(-b) : b;
         neg1_ff <= a[63] ^ b[63];
         p00_ff  <= ua_ff[31:0] * ub_ff[31:0];
         p01_ff  <= ua_ff[31:0] * ub_ff[63:32];
         p10_ff  <= ua_ff[63:32] * ub_ff[31:0];
         p11_ff  <= ua_ff[63:32] * ub_ff[63:32];
         neg2_ff <= neg1_ff;
         sum_ff  <= {p11_ff, p00_ff} + {32'b0, p01_ff, 32'b0} + {32'b0, p10_ff, 32'b0};
         neg3_ff <= neg2_ff;
         prod_ff <= prod_in;
      end
   end

   always_comb begin
      half = frac32 ? (128'd1 << 31) : (128'd1 << 59);
      rnd  = sum_ff + half;
      shf  = frac32 ? (rnd >> 32) : (rnd >> 60);
      mag  = (shf > (128'd1 << 62)) ? (63'd1 << 62) : shf[62:0];
      prod_in = neg3_ff ? -signed'({1'b0, mag}) : signed'({1'b0, mag});
   end

   assign prod = prod_ff;

endmodule

>>> sv/geodetic_to_ecef_core.sv
// Geodetic to ECEF conversion: one item per clock while not stalled; the
// 32-stage sine/cosine CORDIC, the 62-stage square root and the 107-stage bit-per-stage divider
// make up most of the pipeline. The whole pipeline stalls only while a finished result is not taken.
`include "geodetic_to_ecef_core_macros.svh"
module geodetic_to_ecef_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic signed [29:0]                 req_lat_angle,
   input  logic signed [30:0]                 req_lon_angle,
   input  logic signed [47:0]                 req_altitude,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [47:0]                 rsp_x_coord,
   output logic signed [47:0]                 rsp_y_coord,
   output logic signed [47:0]                 rsp_z_coord,
   output logic                               rsp_saturated,
   input  logic                               csr_we,
   input  logic [geo_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [46:0]                        csr_wdata
);
   import geo_pkg::*;

   logic                adv;
   logic [LAT-1:0]      vld_ff;
   logic [46:0]         radius_ff;
   logic [31:0]         ecc_ff;

   logic signed [63:0]  lat_z, lon_z;
   cstage_type          p_in;
   cstage_type          cst_ff [0:CORDIC_STEPS];
   trig_type            trig_in, trig_ff;
   trig_type            side_ff [0:SIDE_LEN-1];
   logic signed [63:0]  s2, e2s2, d_full;
   logic [63:0]         d_ff;
   sqrt_type            sq_ff [0:SQRT_STEPS-1];
   div_type             dv_ff [0:DIV_STEPS-1];
   nh_type              nh_in, nh_ff;
   post_type            post_ff [0:3];
   logic signed [63:0]  zn, hc;
   hz_type              hz_ff;
   logic [3:0]          ovd_ff;
   logic signed [63:0]  xm, ym, zm;
   logic [48:0]         xs, ys, zs;
   logic signed [47:0]  x_ff, y_ff, z_ff;
   logic                sat_ff;

   assign rsp_valid = vld_ff[LAT-1];
   assign adv       = !vld_ff[LAT-1] || rsp_ready;
   assign req_ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         radius_ff <= RADIUS_RESET;
         ecc_ff    <= ECC_RESET;
      end else begin
         if (adv) vld_ff <= {vld_ff[LAT-2:0], req_valid};
         if (csr_we) begin
            unique case (csr_index)
               CSR_RADIUS: radius_ff <= csr_wdata;
               CSR_ECC:    ecc_ff <= csr_wdata[31:0];
            endcase
         end
      end
   end

   // fold angles into +-pi/2
   always_comb begin
      lat_z = {{2{req_lat_angle[29]}}, req_lat_angle, 32'b0};
      lon_z = {req_lon_angle[30], req_lon_angle, 32'b0};
      p_in.lat.x = K_Q60;
      p_in.lat.y = '0;
      p_in.lon.x = K_Q60;
      p_in.lon.y = '0;
      p_in.alt = req_altitude;
      p_in.lat_flip = 1'b1;
      p_in.lon_flip = 1'b1;
      if (lat_z > HALF_PI_Q60) p_in.lat.z = lat_z - PI_Q60;
      else if (lat_z < -HALF_PI_Q60) p_in.lat.z = lat_z + PI_Q60;
      else begin
         p_in.lat.z = lat_z;
         p_in.lat_flip = 1'b0;
      end
      if (lon_z > HALF_PI_Q60) p_in.lon.z = lon_z - PI_Q60;
      else if (lon_z < -HALF_PI_Q60) p_in.lon.z = lon_z + PI_Q60;
      else begin
         p_in.lon.z = lon_z;
         p_in.lon_flip = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) cst_ff[0] <= p_in;
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
      localparam logic signed [63:0] ATAN = atan_q60(i);
      cstage_type cst_in;
      always_comb begin
         cst_in = cst_ff[i];
         cst_in.lat = cordic_step(cst_ff[i].lat, i, ATAN);
         cst_in.lon = cordic_step(cst_ff[i].lon, i, ATAN);
      end
      always_ff @(posedge clock) begin
         if (adv) cst_ff[i+1] <= cst_in;
      end
   end

   always_comb begin
      trig_in.sl  = cst_ff[CORDIC_STEPS].lat_flip ? -cst_ff[CORDIC_STEPS].lat.y
                                                  : cst_ff[CORDIC_STEPS].lat.y;
      trig_in.cl  = cst_ff[CORDIC_STEPS].lat_flip ? -cst_ff[CORDIC_STEPS].lat.x
                                                  : cst_ff[CORDIC_STEPS].lat.x;
      trig_in.so  = cst_ff[CORDIC_STEPS].lon_flip ? -cst_ff[CORDIC_STEPS].lon.y
                                                  : cst_ff[CORDIC_STEPS].lon.y;
      trig_in.co  = cst_ff[CORDIC_STEPS].lon_flip ? -cst_ff[CORDIC_STEPS].lon.x
                                                  : cst_ff[CORDIC_STEPS].lon.x;
      trig_in.alt = cst_ff[CORDIC_STEPS].alt;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         trig_ff <= trig_in;
         side_ff[0] <= trig_ff;
         for (int k = 1; k < SIDE_LEN; k++) side_ff[k] <= side_ff[k-1];
      end
   end

   geo_mul u_mul_s2 (
      .clock(clock), .adv(adv), .frac32(1'b0),
      .a(trig_ff.sl), .b(trig_ff.sl), .prod(s2)
   );

   geo_mul u_mul_e2s2 (
      .clock(clock), .adv(adv), .frac32(1'b0),
      .a(signed'({4'b0, ecc_ff, 28'b0})), .b(s2), .prod(e2s2)
   );

   assign d_full = ONE_Q60 - e2s2;

   always_ff @(posedge clock) begin
      if (adv) d_ff <= (d_full < 64'sd1) ? 64'd1 : d_full;
   end

   for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
      sqrt_type base;
      sqrt_type sq_in;
      logic [1:0] pair;
      if (j == 0) begin : g_first
         assign base = '{rem: '0, root: '0, rad: d_ff};
      end else begin : g_next
         assign base = sq_ff[j-1];
      end
      if (j <= 31) begin : g_pair
         assign pair = base.rad[2*(31-j) +: 2];
      end else begin : g_zero
         assign pair = 2'b00;
      end
      assign sq_in = sqrt_step(base, pair);
      always_ff @(posedge clock) begin
         if (adv) sq_ff[j] <= sq_in;
      end
   end

   for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
      div_type base;
      div_type dv_in;
      logic bitv;
      if (j == 0) begin : g_first
         assign base = '{rem: '0, quo: '0, den: sq_ff[SQRT_STEPS-1].root[60:0], ov: 1'b0};
      end else begin : g_next
         assign base = dv_ff[j-1];
      end
      if (j <= 46) begin : g_bit
         assign bitv = radius_ff[46-j];
      end else begin : g_zero
         assign bitv = 1'b0;
      end
      assign dv_in = div_step(base, bitv);
      always_ff @(posedge clock) begin
         if (adv) dv_ff[j] <= dv_in;
      end
   end

   always_comb begin
      nh_in.ov  = dv_ff[DIV_STEPS-1].ov;
      nh_in.n   = dv_ff[DIV_STEPS-1].ov ? N_CAP : signed'({3'b0, dv_ff[DIV_STEPS-1].quo});
      nh_in.alt = side_ff[SIDE_LEN-1].alt;
      nh_in.h   = nh_in.n + 64'(side_ff[SIDE_LEN-1].alt);
      nh_in.sl  = side_ff[SIDE_LEN-1].sl;
      nh_in.cl  = side_ff[SIDE_LEN-1].cl;
      nh_in.so  = side_ff[SIDE_LEN-1].so;
      nh_in.co  = side_ff[SIDE_LEN-1].co;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         nh_ff <= nh_in;
         post_ff[0] <= '{sl: nh_ff.sl, so: nh_ff.so, co: nh_ff.co, alt: nh_ff.alt, ov: nh_ff.ov};
         for (int k = 1; k < 4; k++) post_ff[k] <= post_ff[k-1];
      end
   end

   geo_mul u_mul_zn (
      .clock(clock), .adv(adv), .frac32(1'b1),
      .a(nh_ff.n), .b(signed'({31'b0, 33'h1_0000_0000 - {1'b0, ecc_ff}})), .prod(zn)
   );

   geo_mul u_mul_hc (
      .clock(clock), .adv(adv), .frac32(1'b0),
      .a(nh_ff.h), .b(nh_ff.cl), .prod(hc)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         hz_ff.hz <= zn + 64'(post_ff[3].alt);
         hz_ff.hc <= hc;
         hz_ff.sl <= post_ff[3].sl;
         hz_ff.so <= post_ff[3].so;
         hz_ff.co <= post_ff[3].co;
         hz_ff.ov <= post_ff[3].ov;
         ovd_ff   <= {ovd_ff[2:0], hz_ff.ov};
      end
   end

   geo_mul u_mul_x (
      .clock(clock), .adv(adv), .frac32(1'b0), .a(hz_ff.hc), .b(hz_ff.co), .prod(xm)
   );

   geo_mul u_mul_y (
      .clock(clock), .adv(adv), .frac32(1'b0), .a(hz_ff.hc), .b(hz_ff.so), .prod(ym)
   );

   geo_mul u_mul_z (
      .clock(clock), .adv(adv), .frac32(1'b0), .a(hz_ff.hz), .b(hz_ff.sl), .prod(zm)
   );

   assign xs = sat48(xm);
   assign ys = sat48(ym);
   assign zs = sat48(zm);

   always_ff @(posedge clock) begin
      if (adv) begin
         x_ff   <= xs[47:0];
         y_ff   <= ys[47:0];
         z_ff   <= zs[47:0];
         sat_ff <= ovd_ff[3] | xs[48] | ys[48] | zs[48];
      end
   end

   assign rsp_x_coord   = x_ff;
   assign rsp_y_coord   = y_ff;
   assign rsp_z_coord   = z_ff;
   assign rsp_saturated = sat_ff;

   `GEO_ASSERT_IMP(a_den_range, clock, reset, vld_ff[IDX_D], (d_ff != 64'd0) && (d_ff <= 64'(ONE_Q60)), "root operand out of range")
   `GEO_ASSERT_IMP(a_root_nonzero, clock, reset, vld_ff[IDX_SQ_LAST], sq_ff[SQRT_STEPS-1].root != 64'd0, "divider sees zero divisor")
   `GEO_ASSERT_NXT(a_ov_flagged, clock, reset, vld_ff[LAT-2] && ovd_ff[3] && adv, rsp_valid && rsp_saturated, "radius overflow not flagged")

endmodule
